>>> hw/rtl/ardec_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the per-field parse function for the ASCII record decoder.
// No dependencies; used by all ardec_* modules and the top level.
package ardec_pkg;

  typedef logic [7:0] char_t;

  localparam int unsigned FIELD_LEN    = 3;
  localparam int unsigned FIELD_COUNT  = 4;
  localparam int unsigned DECODE_SLOTS = FIELD_LEN * FIELD_COUNT;
  localparam int unsigned VAL_W        = 11;

  localparam char_t CR_CODE    = 8'd13;
  localparam char_t SPACE_CODE = 8'd32;
  localparam char_t TAB_CODE   = 8'd9;
  localparam char_t PLUS_CODE  = 8'd43;
  localparam char_t MINUS_CODE = 8'd45;
  localparam char_t ZERO_CODE  = 8'd48;
  localparam char_t NINE_CODE  = 8'd57;

  typedef logic signed [VAL_W-1:0] field_val_t;

  // Write request into the character buffer.
  typedef struct packed {
    logic  en;
    logic  is_cr;
    char_t data;
  } buf_wr_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_DONE
  } parse_phase_t;

  function automatic logic is_blank(input char_t c);
    return (c == SPACE_CODE) || ((c >= TAB_CODE) && (c <= CR_CODE));
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= ZERO_CODE) && (c <= NINE_CODE);
  endfunction

  // Parse up to three characters: skip blanks, optional sign, then digits.
  function automatic field_val_t parse_field(input char_t c [FIELD_LEN]);
    parse_phase_t ph;
    logic         neg;
    logic [9:0]   val;
    logic [3:0]   dig;
    ph  = PH_LEAD;
    neg = 1'b0;
    val = '0;
    for (int k = 0; k < FIELD_LEN; k++) begin
      dig = c[k][3:0];
      unique case (ph)
        PH_LEAD: begin
          if (is_blank(c[k])) begin
            ph = PH_LEAD;
          end else if (c[k] == PLUS_CODE || c[k] == MINUS_CODE) begin
            neg = (c[k] == MINUS_CODE);
            ph  = PH_DIGITS;
          end else if (is_digit(c[k])) begin
            val = {6'd0, dig};
            ph  = PH_DIGITS;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit(c[k])) begin
            val = 10'({val, 3'b000} + {val, 1'b0} + {6'd0, dig});
          end else begin
            ph = PH_DONE;
          end
        end
        default: begin
          ph = PH_DONE;
        end
      endcase
    end
    return neg ? -$signed({1'b0, val}) : $signed({1'b0, val});
  endfunction

endpackage

>>> hw/rtl/ardec_char_buffer.sv
`timescale 1ns / 1ps
// Character buffer and circular write position for the ASCII record decoder.
// Depends on ardec_pkg. Only the decoded slots are stored; higher slots only move the position.
module ardec_char_buffer #(
  parameter int LAST_SLOT = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ardec_pkg::buf_wr_t    wr,
  output ardec_pkg::char_t      slots [ardec_pkg::DECODE_SLOTS]
);

  localparam int POS_W = $clog2(LAST_SLOT + 1);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  ardec_pkg::char_t  slot_r [ardec_pkg::DECODE_SLOTS];
  ardec_pkg::char_t  wr_data;

  // CR stores a terminating zero at the current position.
  assign wr_data = wr.is_cr ? '0 : wr.data;

  always_comb begin
    if (wr.is_cr || pos_r == POS_W'(LAST_SLOT)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int j = 0; j < ardec_pkg::DECODE_SLOTS; j++) begin
        slot_r[j] <= '0;
      end
    end else if (wr.en) begin
      pos_r <= pos_nxt;
      for (int j = 0; j < ardec_pkg::DECODE_SLOTS; j++) begin
        if (pos_r == POS_W'(j)) begin
          slot_r[j] <= wr_data;
        end
      end
    end
  end

  assign slots = slot_r;

endmodule

>>> hw/rtl/ardec_field_parser.sv
`timescale 1ns / 1ps
// Combinational parser for one three-character signed decimal field.
// Depends on ardec_pkg (parse_field).
module ardec_field_parser (
  input  ardec_pkg::char_t     chars [ardec_pkg::FIELD_LEN],
  output ardec_pkg::field_val_t value
);

  assign value = ardec_pkg::parse_field(chars);

endmodule

>>> hw/rtl/ascii_record_field_decoder.sv
`timescale 1ns / 1ps
// Top level of the ASCII record field decoder: handshake control, buffer, four field
// parsers and the result register. Depends on ardec_pkg, ardec_char_buffer, ardec_field_parser.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------------
//   in_     | input     | in_valid / in_stall | in_rx_byte[7:0]
//   out_    | output    | out_valid/out_stall | out_record_done, out_ball_angle,
//           |           |                     | out_ball_distance, out_goal_angle,
//           |           |                     | out_goal_distance (11-bit signed each)
//
// One byte per cycle sustained while the result register is not stalled.
// The buffer update happens at the input transfer; the parse of slots 0-11 then runs
// from the buffer registers into the result register once that register is free.
// Reset (rst_n low, synchronous) clears the buffer, write position and both valid flags.
// in_stall rises only when a byte waits in the parse stage and the result register is
// full and stalled; the buffer must not change before that byte is parsed.
module ascii_record_field_decoder #(
  parameter int LAST_SLOT = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_record_done,
  output logic signed [10:0]          out_ball_angle,
  output logic signed [10:0]          out_ball_distance,
  output logic signed [10:0]          out_goal_angle,
  output logic signed [10:0]          out_goal_distance
);

  localparam int FL = ardec_pkg::FIELD_LEN;

  ardec_pkg::buf_wr_t     buf_wr;
  ardec_pkg::char_t       slots [ardec_pkg::DECODE_SLOTS];
  ardec_pkg::field_val_t  fld_val [ardec_pkg::FIELD_COUNT];
  ardec_pkg::field_val_t  fld_sel [ardec_pkg::FIELD_COUNT];

  // Parse stage: the buffer already reflects this byte; only the CR flag travels.
  logic a_valid_r;
  logic a_cr_r;

  // Result register.
  logic                  out_valid_r;
  logic                  done_r;
  ardec_pkg::field_val_t fld_r [ardec_pkg::FIELD_COUNT];

  logic in_xfer;
  logic out_free;
  logic a_advance;
  logic rx_is_cr;

  // Output register can load when empty or when its transfer completes this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign a_advance = a_valid_r && out_free;
  // Hold the input only while the parse stage is blocked.
  assign in_stall  = a_valid_r && !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign rx_is_cr  = (in_rx_byte == ardec_pkg::CR_CODE);

  // Write the byte (or the CR terminator) into the buffer on every input transfer.
  always_comb begin
    buf_wr.en    = in_xfer;
    buf_wr.is_cr = rx_is_cr;
    buf_wr.data  = in_rx_byte;
  end

  ardec_char_buffer #(
    .LAST_SLOT (LAST_SLOT)
  ) u_buffer (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (buf_wr),
    .slots (slots)
  );

  // Four parsers, each on its own fixed three-slot window.
  for (genvar f = 0; f < ardec_pkg::FIELD_COUNT; f++) begin : g_field
    ardec_pkg::char_t win [FL];
    for (genvar k = 0; k < FL; k++) begin : g_char
      assign win[k] = slots[f*FL + k];
    end
    ardec_field_parser u_parser (
      .chars (win),
      .value (fld_val[f])
    );
    // Drop the parsed value to zero for non-CR bytes.
    assign fld_sel[f] = a_cr_r ? fld_val[f] : '0;
  end

  // Advance the parse stage on input transfer; drain it into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_xfer) begin
      a_valid_r <= 1'b1;
    end else if (a_advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_cr_r <= rx_is_cr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      done_r <= a_cr_r;
      fld_r  <= fld_sel;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_done   = done_r;
  assign out_ball_angle    = fld_r[0];
  assign out_ball_distance = fld_r[1];
  assign out_goal_angle    = fld_r[2];
  assign out_goal_distance = fld_r[3];

  // A stall on the input side only ever comes from a blocked parse stage.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r)
    else $error("in_stall raised with empty parse stage");

  // A CR transfer must reach the parse stage flagged as a record end.
  a_cr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_rx_byte == ardec_pkg::CR_CODE) |=> (a_valid_r && a_cr_r))
    else $error("CR transfer lost before parse stage");

  // A parse stage that is free to drain shows up as a valid result next cycle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("parse stage did not drain into result register");

  // Values are zero unless the result closes a record.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_record_done) |->
      (out_ball_angle == '0 && out_ball_distance == '0 &&
       out_goal_angle == '0 && out_goal_distance == '0))
    else $error("nonzero field on non-record result");

endmodule

>>> dv/tb_ascii_record_field_decoder.sv
`timescale 1ns / 1ps
// Testbench for ascii_record_field_decoder: a queue-fed byte driver, a result monitor
// and a scoreboard that mirrors the character buffer and the four 3-character fields.
// Depends on ardec_pkg (types and character codes) and the RTL of the decoder.
module tb_ascii_record_field_decoder;

  localparam int SLOT_LAST  = 15;
  localparam int LONG_HOLD  = 150;  // one long receiver hold-off, in cycles
  localparam int IDLE_LIMIT = 5000; // cycles with no transfer before the run is abandoned

  // Blank codes the package does not name
  localparam ardec_pkg::char_t LF_CODE = 8'd10;
  localparam ardec_pkg::char_t VT_CODE = 8'd11;
  localparam ardec_pkg::char_t FF_CODE = 8'd12;

  typedef struct packed {
    logic                  done;
    ardec_pkg::field_val_t ball_angle;
    ardec_pkg::field_val_t ball_distance;
    ardec_pkg::field_val_t goal_angle;
    ardec_pkg::field_val_t goal_distance;
  } decoded_rec_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_record_done;
  logic signed [10:0] out_ball_angle;
  logic signed [10:0] out_ball_distance;
  logic signed [10:0] out_goal_angle;
  logic signed [10:0] out_goal_distance;

  // Byte stream waiting to be sent, and decoded records waiting to be seen
  ardec_pkg::char_t byte_q[$];
  decoded_rec_t     record_q[$];

  // Mirror of the block's character buffer and write position
  ardec_pkg::char_t line_buf [0:SLOT_LAST];
  int               wr_slot = 0;

  int n_errors    = 0;
  int n_bytes     = 0;
  int n_records   = 0;
  int n_negative  = 0;
  int n_three_dig = 0;
  int n_checked   = 0;

  ascii_record_field_decoder #(.LAST_SLOT(SLOT_LAST)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_done  (out_record_done),
    .out_ball_angle   (out_ball_angle),
    .out_ball_distance(out_ball_distance),
    .out_goal_angle   (out_goal_angle),
    .out_goal_distance(out_goal_distance)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k <= SLOT_LAST; k++) line_buf[k] = '0;
  end

  // ---------------------------------------------------------------------------
  // Field decode: skip blanks, take one sign, then digits, never past 3 slots.
  // ---------------------------------------------------------------------------
  function automatic logic blank_char(input ardec_pkg::char_t c);
    return (c == ardec_pkg::SPACE_CODE) ||
           (c >= ardec_pkg::TAB_CODE && c <= ardec_pkg::CR_CODE);
  endfunction

  function automatic logic digit_char(input ardec_pkg::char_t c);
    return (c >= ardec_pkg::ZERO_CODE) && (c <= ardec_pkg::NINE_CODE);
  endfunction

  function automatic ardec_pkg::field_val_t decode_slots(input int base);
    int   k;
    int   acc;
    logic neg;
    k   = 0;
    acc = 0;
    neg = 1'b0;
    while (k < ardec_pkg::FIELD_LEN && blank_char(line_buf[base+k])) k++;
    if (k < ardec_pkg::FIELD_LEN && (line_buf[base+k] == ardec_pkg::PLUS_CODE ||
                                     line_buf[base+k] == ardec_pkg::MINUS_CODE)) begin
      neg = (line_buf[base+k] == ardec_pkg::MINUS_CODE);
      k++;
    end
    while (k < ardec_pkg::FIELD_LEN && digit_char(line_buf[base+k])) begin
      acc = acc * 10 + int'(line_buf[base+k] - ardec_pkg::ZERO_CODE);
      k++;
    end
    if (neg) acc = -acc;
    if (acc < 0) n_negative++;
    if (acc >= 100) n_three_dig++;
    return ardec_pkg::field_val_t'(acc);
  endfunction

  // Update the mirror with one accepted byte and queue the result it causes.
  task automatic predict_byte(input ardec_pkg::char_t c);
    decoded_rec_t r;
    r = '0;
    if (c == ardec_pkg::CR_CODE) begin
      line_buf[wr_slot] = '0;
      wr_slot           = 0;
      r.done            = 1'b1;
      r.ball_angle      = decode_slots(0);
      r.ball_distance   = decode_slots(ardec_pkg::FIELD_LEN);
      r.goal_angle      = decode_slots(2 * ardec_pkg::FIELD_LEN);
      r.goal_distance   = decode_slots(3 * ardec_pkg::FIELD_LEN);
      n_records++;
    end else begin
      line_buf[wr_slot] = c;
      wr_slot           = (wr_slot == SLOT_LAST) ? 0 : wr_slot + 1;
    end
    n_bytes++;
    record_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly digits and signs so fields decode to real values; blanks and raw noise
  // bytes (anything but CR) fill the rest.
  function automatic ardec_pkg::char_t record_char();
    int unsigned      r;
    ardec_pkg::char_t c;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      c = ardec_pkg::char_t'(ardec_pkg::ZERO_CODE + $urandom_range(0, 9));
    end else if (r < 60) begin
      c = $urandom_range(0, 1) ? ardec_pkg::MINUS_CODE : ardec_pkg::PLUS_CODE;
    end else if (r < 72) begin
      case ($urandom_range(0, 4))
        0: c = ardec_pkg::TAB_CODE;
        1: c = LF_CODE;
        2: c = VT_CODE;
        3: c = FF_CODE;
        default: c = ardec_pkg::SPACE_CODE;
      endcase
    end else begin
      do c = ardec_pkg::char_t'($urandom_range(0, 255)); while (c == ardec_pkg::CR_CODE);
    end
    return c;
  endfunction

  // Append roughly n bytes: mostly complete 12-character records, some short
  // records that leave stale slots, some long runs that wrap the buffer, and
  // some loose bytes with no CR at all.
  task automatic fill_records(input int n);
    int target;
    int len;
    int unsigned r;
    target = byte_q.size() + n;
    while (byte_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 60)      len = 12;
      else if (r < 80) len = $urandom_range(0, 11);
      else if (r < 90) len = $urandom_range(13, 40);
      else             len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++) byte_q.push_back(record_char());
      if (r < 90) byte_q.push_back(ardec_pkg::CR_CODE);
    end
  endtask

  // Hold the sender back until the block has returned every result.
  task automatic wait_drained();
    while (byte_q.size() != 0 || record_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one byte at a time, hold it while stalled.
  // ---------------------------------------------------------------------------
  int gap_left  = 0;
  int burst_left = 0;

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 2) begin
      burst_left = $urandom_range(30, 90);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_rx_byte);
      // Advance only when nothing is presented or the current byte just transferred.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= byte_q.pop_front();
          gap_left   = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each transferred result, and drive the receiver's stall.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  int   hold_left   = 0;
  int   steady_left = 0;
  logic long_done   = 1'b0;

  always @(posedge clk) begin : result_monitor
    decoded_rec_t want;
    int unsigned  r;
    if (rst_n && out_valid && !out_stall) begin
      if (record_q.size() == 0) begin
        $display("%0t: result with nothing expected, record_done %0d",
                 $time, out_record_done);
        n_errors++;
      end else begin
        want = record_q.pop_front();
        check_field("record_done", want.done, out_record_done);
        check_field("ball_angle", want.ball_angle, out_ball_angle);
        check_field("ball_distance", want.ball_distance, out_ball_distance);
        check_field("goal_angle", want.goal_angle, out_goal_angle);
        check_field("goal_distance", want.goal_distance, out_goal_distance);
        n_checked++;
      end
    end

    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_done && n_checked >= 300) begin
      // Hold off once for a long stretch so the block fills and stalls its input.
      long_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (steady_left > 0) begin
        steady_left--;
        out_stall <= 1'b0;
      end else if (r < 2) begin
        steady_left = $urandom_range(30, 90);
        out_stall <= 1'b0;
      end else if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 97) begin
        hold_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        hold_left = $urandom_range(10, 30);
        out_stall <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: drop the run if no transfer happens on either side for too long.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed records, then random records in three phases,
  // each phase drained before the next so the sender pauses on an empty block.
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    string            first_rec;
    ardec_pkg::char_t odd_rec [12];
    first_rec = "999-99+12 7";
    odd_rec   = '{ardec_pkg::TAB_CODE, ardec_pkg::MINUS_CODE, LF_CODE,
                  ardec_pkg::PLUS_CODE, VT_CODE, 8'd53,
                  FF_CODE, ardec_pkg::SPACE_CODE, 8'd56,
                  8'd255, 8'd0, 8'd57};
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // CR on the freshly cleared buffer: all fields decode to zero.
    byte_q.push_back(ardec_pkg::CR_CODE);
    // Field extremes: 999, -99, plus sign, leading blank, zero byte ending the last field.
    for (int k = 0; k < first_rec.len(); k++) byte_q.push_back(ardec_pkg::char_t'(first_rec[k]));
    byte_q.push_back(ardec_pkg::CR_CODE);
    // Every blank, a sign alone, a sign cut off by a blank, a non-digit first.
    foreach (odd_rec[k]) byte_q.push_back(odd_rec[k]);
    byte_q.push_back(ardec_pkg::CR_CODE);
    // Short record: slots past the first two stay stale from the last one.
    byte_q.push_back(8'd55);
    byte_q.push_back(ardec_pkg::CR_CODE);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      fill_records(640);
      wait_drained();
    end

    // Let any stray result show up before closing.
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes and decoded %0d records; fields gave %0d negative and %0d",
             n_bytes, n_records, n_negative, n_three_dig);
    $display("three-digit values, with buffer wrap, stale slots and stalls on both sides");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
